[sv/d2s_pkg.sv]
// ----------------------------------------------------------------------------
// d2s_pkg
// Shared constants and types of the 3-D depth-to-space index remapper.
// ----------------------------------------------------------------------------
package d2s_pkg;

  localparam int EXT_W    = 13;
  localparam int STRIDE_W = 4;
  localparam int WORD_W   = 32;
  localparam int FAC_W    = 12;

  localparam logic [2:0] REG_CHANNELS = 3'd0;
  localparam logic [2:0] REG_DEPTH    = 3'd1;
  localparam logic [2:0] REG_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_STRIDE_D = 3'd4;
  localparam logic [2:0] REG_STRIDE_H = 3'd5;
  localparam logic [2:0] REG_STRIDE_W = 3'd6;

  typedef struct packed {
    logic [EXT_W-1:0] oc;
    logic [EXT_W-1:0] d;
    logic [EXT_W-1:0] h;
    logic [EXT_W-1:0] w;
    logic [STRIDE_W-1:0] k;
    logic [STRIDE_W-1:0] j;
    logic [STRIDE_W-1:0] i;
  } coords_t;

  typedef struct packed {
    logic [EXT_W-1:0] ch_out;
    logic [EXT_W-1:0] depth;
    logic [EXT_W-1:0] height;
    logic [EXT_W-1:0] width;
    logic [STRIDE_W-1:0] sd;
    logic [STRIDE_W-1:0] sh;
    logic [STRIDE_W-1:0] sw;
  } geom_t;

endpackage

[sv/d2s_div.sv]
// ----------------------------------------------------------------------------
// d2s_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module d2s_div #(
  parameter int NW = 32,
  parameter int DW = 13,
  parameter int PW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] payload_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [PW-1:0] payload_out
);

  logic          vld [NW+1];
  logic [DW-1:0] part [NW+1];
  logic [NW-1:0] acc [NW+1];
  logic [PW-1:0] pay [NW+1];

  assign vld[0]  = in_valid;
  assign part[0] = '0;
  assign acc[0]  = dividend;
  assign pay[0]  = payload_in;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {part[s], acc[s][NW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = !diff[DW];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      part[s+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      acc[s+1]  <= {acc[s][NW-2:0], ge};
      pay[s+1]  <= pay[s];
    end
  end

  assign out_valid   = vld[NW];
  assign quo         = acc[NW];
  assign rem         = part[NW];
  assign payload_out = pay[NW];

endmodule

[sv/d2s_sum.sv]
// ----------------------------------------------------------------------------
// d2s_sum
// Output index assembly: extent products, then multiply and add in three stages.
// ----------------------------------------------------------------------------
module d2s_sum import d2s_pkg::*; #(
  parameter int IW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  geom_t             geom,
  input  logic              in_valid,
  input  coords_t           coords,
  input  logic [IW-1:0]     batch,
  input  logic [WORD_W-1:0] word_in,
  output logic              done,
  output logic [IW-1:0]     index_out,
  output logic [WORD_W-1:0] word_out
);

  localparam int PW = IW + 2*EXT_W + 2*STRIDE_W;

  logic [16:0]   cnt4;
  logic [16:0]   hsh;
  logic [16:0]   dsd;
  logic [IW-1:0] cnt3;
  logic [IW-1:0] cnt2;
  logic [IW-1:0] cnt1;
  logic [PW-1:0] cnt3_full;
  logic [PW-1:0] cnt2_full;
  logic [PW-1:0] cnt1_full;

  assign cnt3_full = hsh * cnt4;
  assign cnt2_full = dsd * cnt3;
  assign cnt1_full = geom.ch_out * cnt2;

  always_ff @(posedge clk) begin
    cnt4 <= geom.width * geom.sw;
    hsh  <= geom.height * geom.sh;
    dsd  <= geom.depth * geom.sd;
    cnt3 <= cnt3_full[IW-1:0];
    cnt2 <= cnt2_full[IW-1:0];
    cnt1 <= cnt1_full[IW-1:0];
  end

  logic              a_valid;
  logic [IW-1:0]     a_p0;
  logic [IW-1:0]     a_p1;
  logic [16:0]       a_dk;
  logic [16:0]       a_hj;
  logic [16:0]       a_wi;
  logic [WORD_W-1:0] a_word;
  logic [2*IW-1:0]   p0_full;
  logic [PW-1:0]     p1_full;

  assign p0_full = batch * cnt1;
  assign p1_full = coords.oc * cnt2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_p0   <= p0_full[IW-1:0];
    a_p1   <= p1_full[IW-1:0];
    a_dk   <= coords.d * geom.sd + 17'(coords.k);
    a_hj   <= coords.h * geom.sh + 17'(coords.j);
    a_wi   <= coords.w * geom.sw + 17'(coords.i);
    a_word <= word_in;
  end

  logic              b_valid;
  logic [IW-1:0]     b_s01;
  logic [IW-1:0]     b_p2;
  logic [IW-1:0]     b_p3;
  logic [16:0]       b_wi;
  logic [WORD_W-1:0] b_word;
  logic [PW-1:0]     p2_full;
  logic [PW-1:0]     p3_full;

  assign p2_full = a_dk * cnt3;
  assign p3_full = a_hj * cnt4;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_s01  <= a_p0 + a_p1;
    b_p2   <= p2_full[IW-1:0];
    b_p3   <= p3_full[IW-1:0];
    b_wi   <= a_wi;
    b_word <= a_word;
  end

  logic [PW-1:0] wi_ext;

  assign wi_ext = PW'(b_wi);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    index_out <= b_s01 + b_p2 + b_p3 + wi_ext[IW-1:0];
    word_out  <= b_word;
  end

endmodule

[sv/depth_to_space_3d_index_map.sv]
// ----------------------------------------------------------------------------
// depth_to_space_3d_index_map
// 3-D depth-to-space index remapper: source element index to output index.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_index and data_word; the word is taken at any edge
//   where busy is low, and busy never rises, so one word enters every cycle.
//   Each word comes back as one result: done high for one cycle with
//   dest_index and out_word. Results leave in the order words entered.
//   Each word passes through the chain of bit-per-stage dividers that split
//   the index by width, height, depth, channels, stride product and the
//   three strides, followed by three multiply and add stages. Throughput is
//   one word per cycle.
//   The receiver cannot stall: results appear on done unconditionally.
//   Configuration goes through cfg_we, cfg_index and cfg_data; write only
//   while no word is in flight. Reset clears all configuration registers
//   to 1 and drops every word in flight.
// ----------------------------------------------------------------------------
module depth_to_space_3d_index_map import d2s_pkg::*; #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       in_index,
  input  logic [WORD_W-1:0] data_word,
  output logic              done,
  output logic [31:0]       dest_index,
  output logic [WORD_W-1:0] out_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [EXT_W-1:0]  cfg_data
);

  localparam int IW  = INDEX_WIDTH;
  localparam int LAT = 4*IW + EXT_W + 3*FAC_W + 3;
  localparam int CW  = $clog2(LAT + 2);

  logic [EXT_W-1:0]    reg_c;
  logic [EXT_W-1:0]    reg_d;
  logic [EXT_W-1:0]    reg_h;
  logic [EXT_W-1:0]    reg_w;
  logic [STRIDE_W-1:0] reg_sd;
  logic [STRIDE_W-1:0] reg_sh;
  logic [STRIDE_W-1:0] reg_sw;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_c  <= EXT_W'(1);
      reg_d  <= EXT_W'(1);
      reg_h  <= EXT_W'(1);
      reg_w  <= EXT_W'(1);
      reg_sd <= STRIDE_W'(1);
      reg_sh <= STRIDE_W'(1);
      reg_sw <= STRIDE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNELS: reg_c  <= cfg_data;
        REG_DEPTH:    reg_d  <= cfg_data;
        REG_HEIGHT:   reg_h  <= cfg_data;
        REG_WIDTH:    reg_w  <= cfg_data;
        REG_STRIDE_D: reg_sd <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_H: reg_sh <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_W: reg_sw <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EXT_W-1:0]    ext_c;
  logic [EXT_W-1:0]    ext_d;
  logic [EXT_W-1:0]    ext_h;
  logic [EXT_W-1:0]    ext_w;
  logic [STRIDE_W-1:0] str_d;
  logic [STRIDE_W-1:0] str_h;
  logic [STRIDE_W-1:0] str_w;
  logic [7:0]          shw;
  logic [FAC_W-1:0]    fac;

  assign ext_c = (reg_c == '0) ? EXT_W'(1) : reg_c;
  assign ext_d = (reg_d == '0) ? EXT_W'(1) : reg_d;
  assign ext_h = (reg_h == '0) ? EXT_W'(1) : reg_h;
  assign ext_w = (reg_w == '0) ? EXT_W'(1) : reg_w;
  assign str_d = (reg_sd == '0) ? STRIDE_W'(1) : reg_sd;
  assign str_h = (reg_sh == '0) ? STRIDE_W'(1) : reg_sh;
  assign str_w = (reg_sw == '0) ? STRIDE_W'(1) : reg_sw;

  always_ff @(posedge clk) begin
    shw <= str_h * str_w;
    fac <= str_d * shw;
  end

  // channel count over stride product, recomputed continuously
  logic [EXT_W-1:0] ch_out;

  d2s_div #(.NW(EXT_W), .DW(FAC_W), .PW(1)) u_div_cf (
    .clk(clk), .rst(rst), .in_valid(1'b1), .dividend(ext_c), .divisor(fac),
    .payload_in(1'b0), .out_valid(), .quo(ch_out), .rem(), .payload_out()
  );

  logic [IW-1:0] x0;

  if (IW >= 32) begin : g_in_wide
    assign x0 = IW'(in_index);
  end else begin : g_in_narrow
    assign x0 = in_index[IW-1:0];
  end

  assign busy = 1'b0;

  // width split
  logic              v1;
  logic [IW-1:0]     q1;
  logic [EXT_W-1:0]  w1;
  logic [WORD_W-1:0] pay1;

  d2s_div #(.NW(IW), .DW(EXT_W), .PW(WORD_W)) u_div_w (
    .clk(clk), .rst(rst), .in_valid(start), .dividend(x0), .divisor(ext_w),
    .payload_in(data_word), .out_valid(v1), .quo(q1), .rem(w1),
    .payload_out(pay1)
  );

  // height split
  localparam int P2 = WORD_W + EXT_W;
  logic          v2;
  logic [IW-1:0] q2;
  logic [EXT_W-1:0] h2;
  logic [P2-1:0] pay2;

  d2s_div #(.NW(IW), .DW(EXT_W), .PW(P2)) u_div_h (
    .clk(clk), .rst(rst), .in_valid(v1), .dividend(q1), .divisor(ext_h),
    .payload_in({w1, pay1}), .out_valid(v2), .quo(q2), .rem(h2),
    .payload_out(pay2)
  );

  // depth split
  localparam int P3 = P2 + EXT_W;
  logic          v3;
  logic [IW-1:0] q3;
  logic [EXT_W-1:0] d3;
  logic [P3-1:0] pay3;

  d2s_div #(.NW(IW), .DW(EXT_W), .PW(P3)) u_div_d (
    .clk(clk), .rst(rst), .in_valid(v2), .dividend(q2), .divisor(ext_d),
    .payload_in({h2, pay2}), .out_valid(v3), .quo(q3), .rem(d3),
    .payload_out(pay3)
  );

  // channel and batch split
  localparam int P4 = P3 + EXT_W;
  logic          v4;
  logic [IW-1:0] n4;
  logic [EXT_W-1:0] c4;
  logic [P4-1:0] pay4;

  d2s_div #(.NW(IW), .DW(EXT_W), .PW(P4)) u_div_c (
    .clk(clk), .rst(rst), .in_valid(v3), .dividend(q3), .divisor(ext_c),
    .payload_in({d3, pay3}), .out_valid(v4), .quo(n4), .rem(c4),
    .payload_out(pay4)
  );

  // stride product split
  localparam int P5 = P4 + IW;
  logic             v5;
  logic [EXT_W-1:0] oc5;
  logic [FAC_W-1:0] pos5;
  logic [P5-1:0]    pay5;

  d2s_div #(.NW(EXT_W), .DW(FAC_W), .PW(P5)) u_div_f (
    .clk(clk), .rst(rst), .in_valid(v4), .dividend(c4), .divisor(fac),
    .payload_in({n4, pay4}), .out_valid(v5), .quo(oc5), .rem(pos5),
    .payload_out(pay5)
  );

  // width offset
  localparam int P6 = P5 + EXT_W;
  logic                v6;
  logic [FAC_W-1:0]    q6;
  logic [STRIDE_W-1:0] i6;
  logic [P6-1:0]       pay6;

  d2s_div #(.NW(FAC_W), .DW(STRIDE_W), .PW(P6)) u_div_sw (
    .clk(clk), .rst(rst), .in_valid(v5), .dividend(pos5), .divisor(str_w),
    .payload_in({oc5, pay5}), .out_valid(v6), .quo(q6), .rem(i6),
    .payload_out(pay6)
  );

  // height offset
  localparam int P7 = P6 + STRIDE_W;
  logic                v7;
  logic [FAC_W-1:0]    q7;
  logic [STRIDE_W-1:0] j7;
  logic [P7-1:0]       pay7;

  d2s_div #(.NW(FAC_W), .DW(STRIDE_W), .PW(P7)) u_div_sh (
    .clk(clk), .rst(rst), .in_valid(v6), .dividend(q6), .divisor(str_h),
    .payload_in({i6, pay6}), .out_valid(v7), .quo(q7), .rem(j7),
    .payload_out(pay7)
  );

  // depth offset
  localparam int P8 = P7 + STRIDE_W;
  logic                v8;
  logic [STRIDE_W-1:0] k8;
  logic [P8-1:0]       pay8;

  d2s_div #(.NW(FAC_W), .DW(STRIDE_W), .PW(P8)) u_div_sd (
    .clk(clk), .rst(rst), .in_valid(v7), .dividend(q7), .divisor(str_d),
    .payload_in({j7, pay7}), .out_valid(v8), .quo(), .rem(k8),
    .payload_out(pay8)
  );

  coords_t           crd;
  geom_t             geom;
  logic [IW-1:0]     batch;
  logic [WORD_W-1:0] word8;
  logic [IW-1:0]     idx_out;

  assign word8  = pay8[WORD_W-1:0];
  assign crd.w  = pay8[WORD_W +: EXT_W];
  assign crd.h  = pay8[WORD_W + EXT_W +: EXT_W];
  assign crd.d  = pay8[WORD_W + 2*EXT_W +: EXT_W];
  assign batch  = pay8[P4 +: IW];
  assign crd.oc = pay8[P5 +: EXT_W];
  assign crd.i  = pay8[P6 +: STRIDE_W];
  assign crd.j  = pay8[P7 +: STRIDE_W];
  assign crd.k  = k8;

  assign geom.ch_out = ch_out;
  assign geom.depth  = ext_d;
  assign geom.height = ext_h;
  assign geom.width  = ext_w;
  assign geom.sd     = str_d;
  assign geom.sh     = str_h;
  assign geom.sw     = str_w;

  d2s_sum #(.IW(IW)) u_sum (
    .clk(clk), .rst(rst), .geom(geom), .in_valid(v8), .coords(crd),
    .batch(batch), .word_in(word8), .done(done), .index_out(idx_out),
    .word_out(out_word)
  );

  if (IW >= 32) begin : g_out_wide
    assign dest_index = idx_out[31:0];
  end else begin : g_out_narrow
    assign dest_index = 32'(idx_out);
  end

  logic [CW-1:0] inflight;
  logic          accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(accept) - CW'(done);
    end
  end

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> inflight != '0)
    else $error("result without a word in flight");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(LAT))
    else $error("more words in flight than pipeline stages");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

[bench/tb_depth_to_space_3d_index_map.sv]
// ----------------------------------------------------------------------------
// tb_depth_to_space_3d_index_map
// Self-checking bench for the 3-D depth-to-space index remapper. Directed
// tables cover reset geometry, extreme indexes and odd register values.
// Random words then run under several geometries. Each word's dest_index is
// predicted from the configured sizes and checked in order.
// ----------------------------------------------------------------------------
module tb_depth_to_space_3d_index_map import d2s_pkg::*; ();

  localparam int LATENCY = 4 * 32 + 52;
  localparam int N_RANDOM = 950;
  localparam longint CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [31:0]       in_index = '0;
  logic [WORD_W-1:0] data_word = '0;
  logic              done;
  logic [31:0]       dest_index;
  logic [WORD_W-1:0] out_word;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [EXT_W-1:0]  cfg_data = '0;

  typedef struct {
    logic [31:0]       idx;
    logic [WORD_W-1:0] word;
  } remap_t;

  typedef struct {
    logic [31:0] idx;
    logic [31:0] word;
    bit          known;
    logic [31:0] result;
  } vector_t;

  remap_t pending_remaps[$];
  logic [63:0] geom[7];
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int geometries = 0;
  longint cycles = 0;

  depth_to_space_3d_index_map uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_index(in_index), .data_word(data_word),
    .done(done), .dest_index(dest_index), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] shuffle_index(logic [31:0] src);
    logic [63:0] cc, dd, hh, ww, sd, sh, sw, f, x;
    logic [63:0] w, h, d, c, n, pos, i, j, k, oc, c4, c3, c2, c1;
    cc = geom[REG_CHANNELS] == 0 ? 1 : geom[REG_CHANNELS];
    dd = geom[REG_DEPTH] == 0 ? 1 : geom[REG_DEPTH];
    hh = geom[REG_HEIGHT] == 0 ? 1 : geom[REG_HEIGHT];
    ww = geom[REG_WIDTH] == 0 ? 1 : geom[REG_WIDTH];
    sd = geom[REG_STRIDE_D] == 0 ? 1 : geom[REG_STRIDE_D];
    sh = geom[REG_STRIDE_H] == 0 ? 1 : geom[REG_STRIDE_H];
    sw = geom[REG_STRIDE_W] == 0 ? 1 : geom[REG_STRIDE_W];
    f = sd * sh * sw;
    x = {32'd0, src};
    w = x % ww; x = x / ww;
    h = x % hh; x = x / hh;
    d = x % dd; x = x / dd;
    c = x % cc; n = x / cc;
    pos = c % f;
    i = pos % sw; pos = pos / sw;
    j = pos % sh; pos = pos / sh;
    k = pos % sd;
    oc = c / f;
    c4 = ww * sw;
    c3 = hh * sh * c4;
    c2 = dd * sd * c3;
    c1 = (cc / f) * c2;
    return 32'(n * c1 + oc * c2 + (d * sd + k) * c3 + (h * sh + j) * c4 + w * sw + i);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [EXT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STRIDE_D || idx == REG_STRIDE_H || idx == REG_STRIDE_W)
      geom[idx] = 64'(value & 13'hF);
    else
      geom[idx] = 64'(value);
  endtask

  task automatic drain_remaps();
    while (pending_remaps.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic set_geometry(logic [EXT_W-1:0] c, logic [EXT_W-1:0] d,
                              logic [EXT_W-1:0] h, logic [EXT_W-1:0] w,
                              logic [EXT_W-1:0] sd, logic [EXT_W-1:0] sh,
                              logic [EXT_W-1:0] sw);
    drain_remaps();
    write_reg(REG_CHANNELS, c);
    write_reg(REG_DEPTH, d);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_STRIDE_D, sd);
    write_reg(REG_STRIDE_H, sh);
    write_reg(REG_STRIDE_W, sw);
    geometries++;
  endtask

  task automatic send_word(logic [31:0] idx, logic [31:0] word, int gap);
    remap_t item;
    in_index <= idx;
    data_word <= word;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    item.idx = shuffle_index(idx);
    item.word = word;
    pending_remaps = {pending_remaps, item};
    words_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    remap_t want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      words_seen++;
      if (pending_remaps.size() == 0) begin
        $error("unexpected result dest_index=%h out_word=%h", dest_index, out_word);
        errors++;
      end else begin
        want = pending_remaps.pop_front();
        if (dest_index !== want.idx) begin
          $error("dest_index expected %h actual %h", want.idx, dest_index);
          errors++;
        end
        if (out_word !== want.word) begin
          $error("out_word expected %h actual %h", want.word, out_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  vector_t directed[] = '{
    '{32'd0, 32'h0000_0000, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h8000_0000, 32'hA5A5_5A5A, 1'b1, 32'h8000_0000},
    '{32'h0000_0001, 32'h5A5A_A5A5, 1'b1, 32'h0000_0001}
  };

  vector_t shuffled[] = '{
    '{32'd0, 32'h1111_1111, 1'b0, 32'd0},
    '{32'd1, 32'h2222_2222, 1'b0, 32'd0},
    '{32'd27, 32'h3333_3333, 1'b0, 32'd0},
    '{32'd1234, 32'h4444_4444, 1'b0, 32'd0},
    '{32'h7FFF_FFFF, 32'h5555_5555, 1'b0, 32'd0},
    '{32'hFFFF_FFFF, 32'h6666_6666, 1'b0, 32'd0}
  };

  task automatic run_table(vector_t rows[]);
    foreach (rows[r]) begin
      if (rows[r].known && shuffle_index(rows[r].idx) !== rows[r].result) begin
        $error("table row %0d dest_index expected %h actual %h", r,
               rows[r].result, shuffle_index(rows[r].idx));
        errors++;
      end
      send_word(rows[r].idx, rows[r].word, pick_gap(1'b0));
    end
    start <= 1'b0;
  endtask

  task automatic run_random(int count);
    logic [31:0] idx;
    bit quiet;
    quiet = $urandom_range(0, 3) == 0;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: idx = $urandom_range(0, 4095);
        1: idx = $urandom();
        2: idx = 32'hFFFF_FFFF - $urandom_range(0, 255);
        default: idx = $urandom() & ~(32'hFFFF_FFFF << $urandom_range(1, 31));
      endcase
      send_word(idx, $urandom(), pick_gap(quiet));
      if (n % 40 == 39) quiet = $urandom_range(0, 3) == 0;
    end
    start <= 1'b0;
  endtask

  initial begin
    foreach (geom[g]) geom[g] = 64'd1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_table(directed);
    set_geometry(13'd24, 13'd3, 13'd5, 13'd7, 13'd2, 13'd3, 13'd2);
    run_table(shuffled);
    set_geometry(13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
    run_table(shuffled);
    set_geometry(13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd8, 13'd8, 13'd8);
    run_table(shuffled);
    set_geometry(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'hF, 13'hF, 13'hF);
    run_table(shuffled);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_geometry(13'd8, 13'd2, 13'd2, 13'd2, 13'd2, 13'd2, 13'd2);
        1: set_geometry(13'd7, 13'd3, 13'd4, 13'd5, 13'd2, 13'd1, 13'd3);
        2: set_geometry(13'd512, 13'd4096, 13'd1, 13'd4096, 13'd8, 13'd8, 13'd8);
        default: set_geometry(EXT_W'($urandom_range(1, 4096)),
                              EXT_W'($urandom_range(1, 64)),
                              EXT_W'($urandom_range(1, 64)),
                              EXT_W'($urandom_range(1, 4096)),
                              EXT_W'($urandom_range(1, 8)),
                              EXT_W'($urandom_range(1, 8)),
                              EXT_W'($urandom_range(0, 15)));
      endcase
      run_random(N_RANDOM / 8);
    end

    drain_remaps();
    $display("remapped %0d words (%0d checked) over %0d geometries", words_sent,
             words_seen, geometries);
    $display("directed extremes, zero and oversize registers, random gaps");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
sv/d2s_pkg.sv
sv/d2s_div.sv
sv/d2s_sum.sv
sv/depth_to_space_3d_index_map.sv
bench/tb_depth_to_space_3d_index_map.sv
